// ===== src/hdlc_pkg.sv =====
// Shared constants, types and the CRC-16 byte update for the HDLC framer.
// No dependencies.
package hdlc_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;
	localparam logic [7:0]  ESC_XOR   = 8'h20;
	localparam logic [15:0] CRC_POLY  = 16'h1021;

	// Position of the framer inside the bytes caused by one request.
	typedef enum logic [5:0] {
		SEG_OPEN  = 6'b000001,
		SEG_ADDR  = 6'b000010,
		SEG_DATA  = 6'b000100,
		SEG_CRCL  = 6'b001000,
		SEG_CRCH  = 6'b010000,
		SEG_CLOSE = 6'b100000
	} seg_t;

	// MSB-first CRC-16, no reflection.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== src/hdlc_frame_transmitter_crc16_top.sv =====
// HDLC framer top level: flags, address, byte stuffing and CRC-16 trailer.
// Depends on hdlc_pkg.
//
// The first line byte of a request passes through the request stage, then the output register.
// Throughput: one line byte per cycle while out_ready is high, set by the single
// output byte register; a request causes 1 to 10 line bytes.
// A new request is taken in the cycle its predecessor hands over its last byte.
// Reset (arst_n low, asynchronous): no frame open, CRC zero, address zero, no output.
module hdlc_frame_transmitter_crc16_top (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] station_address,
	// request channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       frame_last,
	// line byte channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] line_byte,
	output logic       run_last,
	output logic       frame_done
);
	import hdlc_pkg::*;

	// Configuration: the address and its CRC contribution, computed at write time.
	logic [7:0]  addr_q;
	logic [15:0] addr_crc_q;

	// Frame state.
	logic [15:0] crc_q;
	logic        inside_q;

	// Request held while its line bytes are sent out.
	logic        item_valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic [7:0]  addr_s1;
	logic [15:0] crc_s1;
	seg_t        seg_s1;
	logic        esc_s1;   // second half of an escape pair is pending

	// Output register.
	logic        out_valid_q;
	logic [7:0]  line_byte_q;
	logic        run_last_q;
	logic        frame_done_q;

	logic        in_fire;
	logic        load;
	logic [15:0] crc_next;
	logic [7:0]  raw_byte;
	logic        stuffable;
	logic        needs_esc;
	logic [7:0]  emit_byte;
	logic        byte_done;
	logic        item_end;
	seg_t        seg_next;

	assign cfg_ready = 1'b1;

	// Move the next byte into the output register whenever it is free or drained.
	assign load     = item_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !item_valid_s1 || (load && item_end);
	assign in_fire  = in_valid && in_ready;

	// Continue the open frame, or start from the address CRC for a new one.
	assign crc_next = crc_byte(inside_q ? crc_q : addr_crc_q, data_byte);

	// Pick the raw byte for the current position.
	always_comb begin
		raw_byte  = data_s1;
		stuffable = 1'b1;
		seg_next  = SEG_DATA;
		unique case (seg_s1)
			SEG_OPEN: begin
				raw_byte  = FLAG_BYTE;
				stuffable = 1'b0;
				seg_next  = SEG_ADDR;
			end
			SEG_ADDR: begin
				raw_byte = addr_s1;
				seg_next = SEG_DATA;
			end
			SEG_DATA: begin
				raw_byte = data_s1;
				seg_next = SEG_CRCL;
			end
			SEG_CRCL: begin
				raw_byte = crc_s1[7:0];
				seg_next = SEG_CRCH;
			end
			SEG_CRCH: begin
				raw_byte = crc_s1[15:8];
				seg_next = SEG_CLOSE;
			end
			SEG_CLOSE: begin
				raw_byte  = FLAG_BYTE;
				stuffable = 1'b0;
				seg_next  = SEG_CLOSE;
			end
			default: begin
				raw_byte  = data_s1;
				stuffable = 1'b1;
				seg_next  = SEG_DATA;
			end
		endcase
	end

	// Escape flag and escape bytes: send 7D, then the byte with bit 5 flipped.
	assign needs_esc = stuffable && (raw_byte == FLAG_BYTE || raw_byte == ESC_BYTE);
	assign emit_byte = esc_s1 ? (raw_byte ^ ESC_XOR) : (needs_esc ? ESC_BYTE : raw_byte);
	assign byte_done = !needs_esc || esc_s1;
	assign item_end  = byte_done &&
		(seg_s1 == SEG_CLOSE || (seg_s1 == SEG_DATA && !last_s1));

	// Configuration register; takes effect at the next frame opening.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			addr_crc_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			addr_q     <= station_address;
			addr_crc_q <= crc_byte(16'h0000, station_address);
		end
	end

	// Frame state advances as each request is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= '0;
			inside_q <= 1'b0;
		end else if (in_fire) begin
			crc_q    <= frame_last ? 16'h0000 : crc_next;
			inside_q <= !frame_last;
		end
	end

	// Request stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			seg_s1        <= SEG_OPEN;
			esc_s1        <= 1'b0;
		end else if (in_fire) begin
			item_valid_s1 <= 1'b1;
			seg_s1        <= inside_q ? SEG_DATA : SEG_OPEN;
			esc_s1        <= 1'b0;
		end else if (load) begin
			if (item_end) begin
				item_valid_s1 <= 1'b0;
			end
			if (byte_done) begin
				seg_s1 <= seg_next;
				esc_s1 <= 1'b0;
			end else begin
				esc_s1 <= 1'b1;
			end
		end
	end

	// Request stage payload; hold until the next request.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= data_byte;
			last_s1 <= frame_last;
			addr_s1 <= addr_q;
			crc_s1  <= crc_next;
		end
	end

	// Output register: hold while stalled, drop valid once taken with nothing behind.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			line_byte_q  <= emit_byte;
			run_last_q   <= item_end;
			frame_done_q <= (seg_s1 == SEG_CLOSE);
		end
	end

	assign out_valid  = out_valid_q;
	assign line_byte  = line_byte_q;
	assign run_last   = run_last_q;
	assign frame_done = frame_done_q;

endmodule
